// File: rtl/text_cell_console_writer_unit_assert.svh
// ----------------------------------------------------------------------------
// text cell console writer assertion macros
// shared property forms for the console writer checkers
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CELL_CONSOLE_WRITER_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCCW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccw check failed");

// consequent must hold in the cycle after the antecedent
`define TCCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccw check failed");

`endif

// File: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// shared types and constants of the text cell console writer
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLS_DEF  = 80;
  localparam int ROWS_DEF  = 25;
  localparam int OFS_W     = 11;
  localparam int OFS_MAX   = 2047;
  localparam int LINES_MAX = 31;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7e;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] ATTR_BLANK = 8'h0f;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_READ   = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_SETCUR = 3'd3,
    CMD_SCROLL = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       char_code;
    logic [7:0]       attr;
    logic [OFS_W-1:0] position;
    logic             use_cursor;
    logic             move_cursor;
    logic [4:0]       line_count;
  } in_word_t;

  typedef struct packed {
    logic [OFS_W-1:0] new_offset;
    logic [OFS_W-1:0] cursor_pos;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
    logic             write_dropped;
  } out_word_t;

endpackage

// File: rtl/tccw_chan_if.sv
// ----------------------------------------------------------------------------
// tccw_chan_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface tccw_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/tccw_cell_ram.sv
// ----------------------------------------------------------------------------
// tccw_cell_ram
// screen cell store, one write and one registered read port
// ----------------------------------------------------------------------------
module tccw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/tccw_row_div.sv
// ----------------------------------------------------------------------------
// tccw_row_div
// offset modulo column count, registered reciprocal multiply then registered subtract
// ----------------------------------------------------------------------------
module tccw_row_div import tccw_pkg::*; #(
  parameter int COLS = COLS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [OFS_W-1:0] value,
  output logic             done,
  output logic [OFS_W-1:0] rem
);

  // floor(value / COLS) = (value * RECIP) >> SH, exact over the whole offset range
  localparam int LW = $clog2(COLS);
  localparam int SH = OFS_W + LW;
  localparam int MW = OFS_W + 1;
  localparam int PW = OFS_W + MW;
  localparam int QW = PW - SH;

  localparam logic [MW-1:0]    RECIP  = MW'(((1 << SH) + COLS - 1) / COLS);
  localparam logic [OFS_W-1:0] COLS_W = OFS_W'(COLS);

  logic             quo_vld_r, quo_vld_nxt;
  logic             done_r, done_nxt;
  logic [OFS_W-1:0] val_r, val_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [OFS_W-1:0] rem_r, rem_nxt;
  logic [PW-1:0]    prod;
  logic [OFS_W-1:0] back;

  always_comb begin
    prod        = PW'(value) * PW'(RECIP);
    back        = OFS_W'(quo_r) * COLS_W;
    quo_vld_nxt = start;
    done_nxt    = quo_vld_r;
    val_nxt     = val_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    // first step: quotient
    if (start) begin
      val_nxt = value;
      quo_nxt = prod[PW-1:SH];
    end
    // second step: remainder
    if (quo_vld_r) begin
      rem_nxt = val_r - back;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      quo_vld_r <= quo_vld_nxt;
      done_r    <= done_nxt;
    end
    val_r <= val_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/tccw_seq.sv
// ----------------------------------------------------------------------------
// tccw_seq
// command sequencer: read-modify-write of the cell store, sweeps, cursor
// ----------------------------------------------------------------------------
module tccw_seq import tccw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  in_word_t                       in_word,
  input  logic [7:0]                     default_attr,
  output logic                           res_valid,
  input  logic                           res_load,
  output out_word_t                      res,
  output logic                           div_start,
  output logic [OFS_W-1:0]               div_value,
  input  logic                           div_done,
  input  logic [OFS_W-1:0]               div_rem,
  output logic                           ram_we,
  output logic [$clog2(COLS*ROWS)-1:0]   ram_waddr,
  output logic [15:0]                    ram_wdata,
  output logic                           ram_re,
  output logic [$clog2(COLS*ROWS)-1:0]   ram_raddr,
  input  logic [15:0]                    ram_rdata
);

  localparam int CELLS   = COLS * ROWS;
  localparam int AW      = $clog2(CELLS);
  localparam int IDX_LIM = (CELLS > OFS_MAX + 1) ? CELLS : OFS_MAX + 1;
  localparam int SW      = $clog2(IDX_LIM + COLS * LINES_MAX + 1);

  localparam logic [SW-1:0] CELLS_S   = SW'(CELLS);
  localparam logic [SW-1:0] COLS_S    = SW'(COLS);
  localparam logic [SW-1:0] OFS_MAX_S = SW'(OFS_MAX);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_PUT  = 12'b0000_0000_0010,
    S_BS   = 12'b0000_0000_0100,
    S_DIV  = 12'b0000_0000_1000,
    S_PEND = 12'b0000_0001_0000,
    S_RDC  = 12'b0000_0010_0000,
    S_SCR0 = 12'b0000_0100_0000,
    S_SCR1 = 12'b0000_1000_0000,
    S_CPRD = 12'b0001_0000_0000,
    S_CPWR = 12'b0010_0000_0000,
    S_FILL = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic             boot_r, boot_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic [7:0]       at_r, at_nxt;
  logic             mov_r, mov_nxt;
  logic [4:0]       lines_r, lines_nxt;
  logic [OFS_W-1:0] ofs_r, ofs_nxt;
  logic [OFS_W-1:0] cursor_r, cursor_nxt;
  logic [OFS_W-1:0] new_ofs_r, new_ofs_nxt;
  logic [7:0]       rd_ch_r, rd_ch_nxt;
  logic [7:0]       rd_at_r, rd_at_nxt;
  logic             scr_r, scr_nxt;
  logic             drop_r, drop_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [SW-1:0]    start_r, start_nxt;
  logic [SW-1:0]    end_r, end_nxt;
  logic [SW-1:0]    dist_r, dist_nxt;
  logic [SW-1:0]    fill_last_r, fill_last_nxt;
  logic [15:0]      fill_word_r, fill_word_nxt;
  logic             src_ok_r, src_ok_nxt;

  logic [SW-1:0]    ofs_ext;
  logic [SW-1:0]    ofs_dec;
  logic [SW-1:0]    sum;
  logic [SW-1:0]    src;
  logic [SW-1:0]    pos_ext;
  logic [SW-1:0]    scr_start;

  always_comb begin
    state_nxt     = state_r;
    boot_nxt      = boot_r;
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    at_nxt        = at_r;
    mov_nxt       = mov_r;
    lines_nxt     = lines_r;
    ofs_nxt       = ofs_r;
    cursor_nxt    = cursor_r;
    new_ofs_nxt   = new_ofs_r;
    rd_ch_nxt     = rd_ch_r;
    rd_at_nxt     = rd_at_r;
    scr_nxt       = scr_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    dist_nxt      = dist_r;
    fill_last_nxt = fill_last_r;
    fill_word_nxt = fill_word_r;
    src_ok_nxt    = src_ok_r;

    ofs_ext   = SW'(ofs_r);
    ofs_dec   = (ofs_r != '0) ? ofs_ext - 1'b1 : ofs_ext;
    sum       = ofs_ext + 1'b1;
    src       = idx_r + dist_r;
    pos_ext   = SW'(in_word.position);
    scr_start = ((end_r < COLS_S) || (end_r < dist_r)) ? '0 : end_r - dist_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    div_start = 1'b0;
    div_value = ofs_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = fill_word_r;
    ram_re    = 1'b0;
    ram_raddr = src[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt     = in_word.cmd;
          ch_nxt      = (in_word.char_code == CH_TAB) ? CH_SPACE : in_word.char_code;
          at_nxt      = (in_word.attr == '0) ? default_attr : in_word.attr;
          mov_nxt     = in_word.move_cursor;
          lines_nxt   = in_word.line_count;
          ofs_nxt     = in_word.use_cursor ? cursor_r : in_word.position;
          new_ofs_nxt = cursor_r;
          rd_ch_nxt   = '0;
          rd_at_nxt   = '0;
          scr_nxt     = 1'b0;
          drop_nxt    = 1'b0;
          unique case (in_word.cmd)
            CMD_PUT: state_nxt = S_PUT;
            CMD_READ: begin
              if (pos_ext < CELLS_S) begin
                ram_re    = 1'b1;
                ram_raddr = pos_ext[AW-1:0];
                state_nxt = S_RDC;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_CLEAR: begin
              idx_nxt       = '0;
              fill_last_nxt = CELLS_S - 1'b1;
              fill_word_nxt = {in_word.attr, CH_SPACE};
              cursor_nxt    = '0;
              new_ofs_nxt   = '0;
              state_nxt     = S_FILL;
            end
            CMD_SETCUR: begin
              cursor_nxt  = in_word.position;
              new_ofs_nxt = in_word.position;
              state_nxt   = S_DONE;
            end
            CMD_SCROLL: state_nxt = S_SCR0;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PUT: begin
        if (ch_r == CH_NL) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (ch_r == CH_BS) begin
          ofs_nxt = ofs_dec[OFS_W-1:0];
          if (ofs_dec < CELLS_S) begin
            ram_re    = 1'b1;
            ram_raddr = ofs_dec[AW-1:0];
            state_nxt = S_BS;
          end else begin
            drop_nxt  = 1'b1;
            state_nxt = S_PEND;
          end
        end else if (ch_r >= CH_SPACE && ch_r <= CH_TILDE) begin
          if (ofs_ext < CELLS_S) begin
            ram_we    = 1'b1;
            ram_waddr = ofs_ext[AW-1:0];
            ram_wdata = {at_r, ch_r};
          end else begin
            drop_nxt = 1'b1;
          end
          ofs_nxt   = (sum > OFS_MAX_S) ? OFS_W'(OFS_MAX) : sum[OFS_W-1:0];
          state_nxt = S_PEND;
        end else begin
          state_nxt = S_PEND;
        end
      end
      S_BS: begin
        // keep the attribute, blank the character
        ram_we    = 1'b1;
        ram_waddr = ofs_ext[AW-1:0];
        ram_wdata = {ram_rdata[15:8], CH_SPACE};
        state_nxt = S_PEND;
      end
      S_DIV: begin
        if (div_done) begin
          sum       = ofs_ext + COLS_S - SW'(div_rem);
          ofs_nxt   = (sum > OFS_MAX_S) ? OFS_W'(OFS_MAX) : sum[OFS_W-1:0];
          state_nxt = S_PEND;
        end
      end
      S_PEND: begin
        new_ofs_nxt = ofs_r;
        state_nxt   = S_DONE;
        if (mov_r) begin
          cursor_nxt = ofs_r;
          if (ofs_ext > CELLS_S - 1'b1) begin
            lines_nxt = 5'd1;
            state_nxt = S_SCR0;
          end
        end
      end
      S_RDC: begin
        rd_ch_nxt = ram_rdata[7:0];
        rd_at_nxt = ram_rdata[15:8];
        state_nxt = S_DONE;
      end
      S_SCR0: begin
        dist_nxt  = SW'(COLS_S * SW'(lines_r));
        end_nxt   = SW'(cursor_r);
        scr_nxt   = 1'b1;
        state_nxt = S_SCR1;
      end
      S_SCR1: begin
        start_nxt     = scr_start;
        cursor_nxt    = scr_start[OFS_W-1:0];
        if (cmd_r == CMD_SCROLL) begin
          new_ofs_nxt = scr_start[OFS_W-1:0];
        end
        fill_word_nxt = {ATTR_BLANK, CH_SPACE};
        fill_last_nxt = end_r;
        idx_nxt       = '0;
        state_nxt     = (scr_start == '0) ? S_FILL : S_CPRD;
      end
      S_CPRD: begin
        src_ok_nxt = (src < CELLS_S);
        ram_re     = (src < CELLS_S);
        state_nxt  = S_CPWR;
      end
      S_CPWR: begin
        if (idx_r < CELLS_S) begin
          ram_we    = 1'b1;
          ram_wdata = src_ok_r ? ram_rdata : {ATTR_BLANK, CH_SPACE};
        end else begin
          drop_nxt = 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = (idx_r + 1'b1 == start_r) ? S_FILL : S_CPRD;
      end
      S_FILL: begin
        if (idx_r < CELLS_S) begin
          ram_we = 1'b1;
        end else begin
          drop_nxt = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == fill_last_r) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      boot_r      <= 1'b1;
      idx_r       <= '0;
      fill_last_r <= CELLS_S - 1'b1;
      fill_word_r <= {ATTR_RESET, CH_SPACE};
      cursor_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      idx_r       <= idx_nxt;
      fill_last_r <= fill_last_nxt;
      fill_word_r <= fill_word_nxt;
      cursor_r    <= cursor_nxt;
    end
    cmd_r     <= cmd_nxt;
    ch_r      <= ch_nxt;
    at_r      <= at_nxt;
    mov_r     <= mov_nxt;
    lines_r   <= lines_nxt;
    ofs_r     <= ofs_nxt;
    new_ofs_r <= new_ofs_nxt;
    rd_ch_r   <= rd_ch_nxt;
    rd_at_r   <= rd_at_nxt;
    scr_r     <= scr_nxt;
    drop_r    <= drop_nxt;
    start_r   <= start_nxt;
    end_r     <= end_nxt;
    dist_r    <= dist_nxt;
    src_ok_r  <= src_ok_nxt;
  end

  assign res.new_offset    = new_ofs_r;
  assign res.cursor_pos    = cursor_r;
  assign res.cell_char     = rd_ch_r;
  assign res.cell_attr     = rd_at_r;
  assign res.scrolled      = scr_r;
  assign res.write_dropped = drop_r;

endmodule

// File: rtl/text_cell_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_cell_console_writer_unit
// character-cell text console: put, read, clear, set cursor, scroll
// ----------------------------------------------------------------------------
// The screen is COLS x ROWS cells of {attribute, character} held in one
// synchronous RAM, plus an 11-bit cursor. One command word is taken at a
// time and gives exactly one result word. After reset the block fills the
// screen with spaces in attribute 0x07 and takes no command word until that
// pass ends; the default_attr register can be written at any time. The
// sequencer drives the RAM's one write and one registered read port: read
// cell reads the cell, backspace reads the cell and then writes it back with
// the character blanked, newline uses the reciprocal offset/COLS step, clear
// writes every cell. Scroll moves each kept cell with one read and one
// write, then blanks the cells that are left; a put with move_cursor past
// the last cell is followed by a scroll of one line. A finished result
// sits in the output register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
module text_cell_console_writer_unit import tccw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  tccw_chan_if.sink          in_ch,
  tccw_chan_if.source        out_ch,
  tccw_chan_if.sink          cfg_ch
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // configuration register
  logic [7:0] default_attr_r, default_attr_nxt;

  // output word register
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;

  // sequencer handshake
  logic       res_valid;
  logic       res_load;
  out_word_t  res;

  // row divide unit
  logic             div_start;
  logic [OFS_W-1:0] div_value;
  logic             div_done;
  logic [OFS_W-1:0] div_rem;

  // cell store port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // register is always writable
  assign cfg_ch.ready = 1'b1;

  // load the result when the output slot is empty or being drained
  assign res_load = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    default_attr_nxt = default_attr_r;
    if (cfg_ch.valid) begin
      default_attr_nxt = cfg_ch.data;
    end

    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= ATTR_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      default_attr_r <= default_attr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // command sequencer
  tccw_seq #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_word      (in_ch.data),
    .default_attr (default_attr_r),
    .res_valid    (res_valid),
    .res_load     (res_load),
    .res          (res),
    .div_start    (div_start),
    .div_value    (div_value),
    .div_done     (div_done),
    .div_rem      (div_rem),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // offset modulo COLS for newline
  tccw_row_div #(
    .COLS (COLS)
  ) u_row_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (div_value),
    .done  (div_done),
    .rem   (div_rem)
  );

  // screen cells
  tccw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: rtl/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// port-level checks of the text cell console writer
// ----------------------------------------------------------------------------
`include "text_cell_console_writer_unit_assert.svh"

module tccw_checker import tccw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a stalled result word stays put
  `TCCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // one command at a time: no word taken in the cycle after an accept
  `TCCW_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // a scrolling word never carries read data
  `TCCW_ASSERT_NOW(a_scroll_no_read, out_valid && out_word.scrolled,
                   out_word.cell_char == 8'd0 && out_word.cell_attr == 8'd0)

endmodule

bind text_cell_console_writer_unit tccw_checker u_tccw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.data)
);
